// ===== rtl/usb_endpoint_descriptor_selector_unit_macros.svh =====
// Assertion helpers shared by the selector RTL.
// Both expect signals named clk and rst in the module that uses them.
`ifndef USB_ENDPOINT_DESCRIPTOR_SELECTOR_UNIT_MACROS_SVH
`define USB_ENDPOINT_DESCRIPTOR_SELECTOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EDS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/usb_eds_pkg.sv =====
`default_nettype none

package usb_eds_pkg;

  // Descriptor type codes and minimum lengths.
  localparam logic [7:0] DT_INTERFACE     = 8'h04;
  localparam logic [7:0] DT_ENDPOINT      = 8'h05;
  localparam logic [7:0] DESC_MIN_LEN     = 8'd2;
  localparam logic [7:0] IF_DESC_MIN_LEN  = 8'd9;
  localparam logic [7:0] EP_DESC_MIN_LEN  = 8'd7;

  // Endpoint transfer types that may be selected.
  localparam logic [1:0] XFER_BULK = 2'd2;
  localparam logic [1:0] XFER_INTR = 2'd3;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_WANTED_INTERFACE   = 3'd0,
    REG_WANTED_ALTERNATE   = 3'd1,
    REG_WANTED_IN_ADDRESS  = 3'd2,
    REG_WANTED_OUT_ADDRESS = 3'd3,
    REG_WANTED_IN_PACKET   = 3'd4,
    REG_WANTED_OUT_PACKET  = 3'd5,
    REG_BULK_READ_BYTES    = 3'd6,
    REG_INTERRUPT_IN_ONLY  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [7:0]  wanted_interface;
    logic [7:0]  wanted_alternate;
    logic [7:0]  wanted_in_address;
    logic [7:0]  wanted_out_address;
    logic [10:0] wanted_in_packet;
    logic [10:0] wanted_out_packet;
    logic [15:0] bulk_read_bytes;
    logic        interrupt_in_only;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  address;
    logic [1:0]  transfer;
    logic [10:0] max_packet;
    logic [15:0] wmax_raw;
  } endpoint_t;

  typedef struct packed {
    logic found;
    logic in_alt;
    logic error;
  } alt_flags_t;

  typedef struct packed {
    alt_flags_t flags;
    endpoint_t  in_ep;
    endpoint_t  out_ep;
  } walk_status_t;

  // Result payload, last field (in_address) in the lowest bits.
  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] out_read_size;
    logic [10:0] out_max_packet;
    logic [1:0]  out_transfer;
    logic [7:0]  out_address;
    logic [15:0] in_read_size;
    logic [10:0] in_max_packet;
    logic [1:0]  in_transfer;
    logic [7:0]  in_address;
  } result_data_t;

  typedef enum logic [1:0] {
    ST_WALK,
    ST_LOAD,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/usb_eds_modunit.sv =====
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle while busy, over all 16 dividend bits.
module usb_eds_modunit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [10:0] divisor,
  output logic             busy,
  output logic [10:0]      remainder
);
  import usb_eds_pkg::*;

  logic [15:0] shift_reg;
  logic [3:0]  count;
  logic [11:0] trial;
  logic [11:0] trial_diff;
  logic        trial_ge;

  // One shift-and-subtract step.
  always_comb begin
    trial      = {remainder, shift_reg[15]};
    trial_ge   = (trial >= {1'b0, divisor});
    trial_diff = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= 4'd0;
    end else if (start) begin
      busy      <= 1'b1;
      count     <= 4'd15;
      shift_reg <= dividend;
      remainder <= 11'd0;
    end else if (busy) begin
      shift_reg <= {shift_reg[14:0], 1'b0};
      remainder <= trial_ge ? trial_diff[10:0] : trial[10:0];
      count     <= count - 4'd1;
      if (count == 4'd0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/usb_eds_walker.sv =====
`default_nettype none

`include "usb_endpoint_descriptor_selector_unit_macros.svh"

// Descriptor walker: follows length and type of each descriptor one byte
// per transaction and keeps the first matching IN and OUT endpoint.
module usb_eds_walker (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic [7:0]                desc_byte,
  input  wire logic                      last_byte,
  input  wire logic                      clear,
  input  wire usb_eds_pkg::cfg_t         cfg,
  output usb_eds_pkg::walk_status_t      status
);
  import usb_eds_pkg::*;

  logic [7:0] byte_offset, byte_offset_next;
  logic [7:0] desc_length, desc_length_next;
  logic [7:0] desc_type, desc_type_next;
  logic [7:0] latch_addr, latch_addr_next;
  logic [1:0] latch_xfer, latch_xfer_next;
  logic [7:0] latch_size_lo, latch_size_lo_next;
  alt_flags_t flags, flags_next;
  endpoint_t  in_ep, in_ep_next;
  endpoint_t  out_ep, out_ep_next;

  logic        err;
  logic [7:0]  off_inc;
  logic [15:0] raw_size;

  // Keeps the first endpoint that matches; a wanted value of zero takes any.
  function automatic endpoint_t ep_offer(input endpoint_t ep,
                                         input logic [7:0] want_addr,
                                         input logic [10:0] want_size,
                                         input logic [7:0] addr,
                                         input logic [1:0] xfer,
                                         input logic [15:0] raw);
    endpoint_t res;
    logic      take;
    res  = ep;
    take = (ep.address == 8'd0)
        && ((want_addr == 8'd0) || (addr == want_addr))
        && ((want_size == 11'd0) || (raw[10:0] == want_size));
    if (take) begin
      res.address    = addr;
      res.transfer   = xfer;
      res.max_packet = raw[10:0];
      res.wmax_raw   = raw;
    end
    return res;
  endfunction

  // Next walk state for one byte.
  always_comb begin
    byte_offset_next   = byte_offset;
    desc_length_next   = desc_length;
    desc_type_next     = desc_type;
    latch_addr_next    = latch_addr;
    latch_xfer_next    = latch_xfer;
    latch_size_lo_next = latch_size_lo;
    flags_next         = flags;
    in_ep_next         = in_ep;
    out_ep_next        = out_ep;
    err                = 1'b0;
    off_inc            = 8'd0;
    raw_size           = {desc_byte, latch_size_lo};

    if (accept && !flags.error) begin
      if (byte_offset == 8'd0) begin
        desc_length_next = desc_byte;
        if (last_byte) begin
          err = 1'b1;
        end
      end else if (byte_offset == 8'd1) begin
        desc_type_next = desc_byte;
        if (desc_length < DESC_MIN_LEN) begin
          err = 1'b1;
        end else if (desc_byte == DT_INTERFACE && desc_length < IF_DESC_MIN_LEN) begin
          err = 1'b1;
        end else if (desc_byte == DT_ENDPOINT && desc_length < EP_DESC_MIN_LEN) begin
          err = 1'b1;
        end
      end else if (desc_type == DT_INTERFACE) begin
        // Interface number, then alternate setting.
        if (byte_offset == 8'd2) begin
          latch_addr_next    = desc_byte;
          latch_xfer_next    = 2'd0;
          latch_size_lo_next = 8'd0;
        end else if (byte_offset == 8'd3) begin
          if (latch_addr == cfg.wanted_interface && desc_byte == cfg.wanted_alternate) begin
            flags_next.in_alt = 1'b1;
            flags_next.found  = 1'b1;
          end else begin
            flags_next.in_alt = 1'b0;
          end
        end
      end else if (desc_type == DT_ENDPOINT) begin
        // Address, attributes, then the two bytes of wMaxPacketSize.
        if (byte_offset == 8'd2) begin
          latch_addr_next    = desc_byte;
          latch_xfer_next    = 2'd0;
          latch_size_lo_next = 8'd0;
        end else if (byte_offset == 8'd3) begin
          latch_xfer_next = desc_byte[1:0];
        end else if (byte_offset == 8'd4) begin
          latch_size_lo_next = desc_byte;
        end else if (byte_offset == 8'd5) begin
          if (flags.in_alt && (latch_xfer == XFER_BULK || latch_xfer == XFER_INTR)) begin
            if (latch_addr[7]) begin
              if (latch_xfer == XFER_INTR || !cfg.interrupt_in_only) begin
                in_ep_next = ep_offer(in_ep, cfg.wanted_in_address, cfg.wanted_in_packet,
                                      latch_addr, latch_xfer, raw_size);
              end
            end else begin
              out_ep_next = ep_offer(out_ep, cfg.wanted_out_address, cfg.wanted_out_packet,
                                     latch_addr, latch_xfer, raw_size);
            end
          end
        end
      end

      // Advance the position unless the blob is already malformed.
      if (!err) begin
        off_inc = byte_offset + 8'd1;
        if (off_inc >= DESC_MIN_LEN && off_inc >= desc_length_next) begin
          byte_offset_next = 8'd0;
        end else begin
          byte_offset_next = off_inc;
        end
        if (last_byte && byte_offset_next != 8'd0) begin
          err = 1'b1;
        end
      end
      flags_next.error = err;
    end
  end

  // Walk state registers; clear returns them to reset after a result.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      byte_offset   <= 8'd0;
      desc_length   <= 8'd0;
      desc_type     <= 8'd0;
      latch_addr    <= 8'd0;
      latch_xfer    <= 2'd0;
      latch_size_lo <= 8'd0;
      flags         <= '0;
      in_ep         <= '0;
      out_ep        <= '0;
    end else begin
      byte_offset   <= byte_offset_next;
      desc_length   <= desc_length_next;
      desc_type     <= desc_type_next;
      latch_addr    <= latch_addr_next;
      latch_xfer    <= latch_xfer_next;
      latch_size_lo <= latch_size_lo_next;
      flags         <= flags_next;
      in_ep         <= in_ep_next;
      out_ep        <= out_ep_next;
    end
  end

  assign status.flags  = flags;
  assign status.in_ep  = in_ep;
  assign status.out_ep = out_ep;

  // Checks on the walk state.
  `EDS_ASSERT_NEXT(a_clear_walk, clear, (byte_offset == 8'd0) && (flags == '0), "walk state not cleared")
  `EDS_ASSERT_SAME(a_found_when_in_alt, flags.in_alt, flags.found, "in alternate without found")
  `EDS_ASSERT_NEXT(a_error_sticky, flags.error && !clear, flags.error, "error flag dropped")
  `EDS_ASSERT_NEXT(a_in_ep_kept, (in_ep.address != 8'd0) && !clear, $stable(in_ep), "IN endpoint replaced")

endmodule

`default_nettype wire

// ===== rtl/usb_endpoint_descriptor_selector_unit.sv =====
`default_nettype none

`include "usb_endpoint_descriptor_selector_unit_macros.svh"

// Channel   Dir  tdata                                         tuser  tlast
// s_axis    in   [7:0] desc_byte                               -      last_byte
// m_axis    out  in_address, in_transfer, in_max_packet,       [0] ok -
//                in_read_size, out_address, out_transfer,
//                out_max_packet, out_read_size (80 bits)
// cfg       in   cfg_index selects register, cfg_wdata value   -      -
//
// A descriptor byte that is not the last one is taken as soon as it is offered.
// The last byte starts a 16-step remainder check in the remainder unit; the
// result is loaded after the LOAD, CHECK and DONE states, and ready stays low
// until it is in the output register (longer while the output is stalled).
// Synchronous reset clears the walk and the configuration registers.
module usb_endpoint_descriptor_selector_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] desc_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // in_address, in_transfer, in_max_packet,
                                           // in_read_size, out_address, out_transfer,
                                           // out_max_packet, out_read_size, zero pad
  output logic [0:0]       m_axis_tuser,   // [0] ok
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import usb_eds_pkg::*;

  cfg_t         cfg;
  walk_status_t status;
  state_t       state, state_next;
  logic         s_accept;
  logic         walk_clear;
  logic         div_start;
  logic         div_busy;
  logic [10:0]  div_rem;
  logic         load_result;
  logic         bulk_check;
  logic         ok;
  result_data_t result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_WANTED_INTERFACE:   cfg.wanted_interface   <= cfg_wdata[7:0];
        REG_WANTED_ALTERNATE:   cfg.wanted_alternate   <= cfg_wdata[7:0];
        REG_WANTED_IN_ADDRESS:  cfg.wanted_in_address  <= cfg_wdata[7:0];
        REG_WANTED_OUT_ADDRESS: cfg.wanted_out_address <= cfg_wdata[7:0];
        REG_WANTED_IN_PACKET:   cfg.wanted_in_packet   <= cfg_wdata[10:0];
        REG_WANTED_OUT_PACKET:  cfg.wanted_out_packet  <= cfg_wdata[10:0];
        REG_BULK_READ_BYTES:    cfg.bulk_read_bytes    <= cfg_wdata;
        REG_INTERRUPT_IN_ONLY:  cfg.interrupt_in_only  <= cfg_wdata[0];
        default:                cfg                    <= cfg;
      endcase
    end
  end

  assign s_accept = s_axis_tvalid && s_axis_tready;

  usb_eds_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_accept),
    .desc_byte (s_axis_tdata),
    .last_byte (s_axis_tlast),
    .clear     (walk_clear),
    .cfg       (cfg),
    .status    (status)
  );

  usb_eds_modunit u_modunit (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (cfg.bulk_read_bytes),
    .divisor   (status.in_ep.max_packet),
    .busy      (div_busy),
    .remainder (div_rem)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WALK;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    load_result   = 1'b0;
    walk_clear    = 1'b0;
    unique case (state)
      ST_WALK: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && s_axis_tlast) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        div_start  = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!div_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_result = 1'b1;
          walk_clear  = 1'b1;
          state_next  = ST_WALK;
        end
      end
      default: state_next = ST_WALK;
    endcase
  end

  // Final verdict and the result fields.
  always_comb begin
    bulk_check = (cfg.bulk_read_bytes != 16'd0) && (status.in_ep.transfer == XFER_BULK);
    ok = !status.flags.error && status.flags.found && (status.in_ep.address != 8'd0);
    if (cfg.wanted_out_address != 8'd0 && status.out_ep.address == 8'd0) begin
      ok = 1'b0;
    end
    if (bulk_check && (status.in_ep.max_packet == 11'd0 || div_rem != 11'd0)) begin
      ok = 1'b0;
    end
    result = '0;
    if (ok) begin
      result.in_address     = status.in_ep.address;
      result.in_transfer    = status.in_ep.transfer;
      result.in_max_packet  = status.in_ep.max_packet;
      result.in_read_size   = bulk_check ? cfg.bulk_read_bytes : status.in_ep.wmax_raw;
      result.out_address    = status.out_ep.address;
      result.out_transfer   = status.out_ep.transfer;
      result.out_max_packet = status.out_ep.max_packet;
      result.out_read_size  = status.out_ep.wmax_raw;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_result) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      m_axis_tdata <= result;
      m_axis_tuser <= ok;
    end
  end

  // Checks on the sequencer and the result.
  `EDS_ASSERT_SAME(a_ready_only_walking, s_axis_tready, state == ST_WALK, "ready outside walk")
  `EDS_ASSERT_SAME(a_fail_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "failed result not zero")
  `EDS_ASSERT_NEXT(a_check_after_load, state == ST_LOAD, (state == ST_CHECK) && div_busy, "remainder unit not started")

endmodule

`default_nettype wire
